/* design/c2xu_pkg.sv */
`timescale 1ns / 1ps
package c2xu_pkg;

	// index width of a source or output coordinate
	localparam int DIM_W = 7;
	localparam int SAMPLE_W = 16;
	localparam int PIX_W = 25;
	// tap weights and their products
	localparam int WT_W = 6;
	localparam int WPROD_W = 10;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic REG_IMAGE_WIDTH = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] DIM_RESET = 7'd8;

	localparam logic signed [WT_W-1:0] UNIT_WEIGHT = 6'sd16;
	localparam logic signed [WT_W-1:0] TAP_WEIGHT [4] = '{-6'sd1, 6'sd9, 6'sd9, -6'sd1};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_FINISH
	} c2xu_state_t;

	typedef struct packed {
		logic write;
		logic start;
		logic issue;
		logic load;
	} c2xu_cmd_t;

	typedef struct packed {
		logic is_read;
		logic oor;
		logic last_issue;
	} c2xu_sts_t;

endpackage

/* design/c2xu_req_if.sv */
`timescale 1ns / 1ps
interface c2xu_req_if;
	logic valid;
	logic ready;
	logic operation;
	logic [6:0] row_index;
	logic [6:0] column_index;
	logic signed [15:0] sample_in;

	modport source (output valid, operation, row_index, column_index, sample_in, input ready);
	modport sink (input valid, operation, row_index, column_index, sample_in, output ready);
endinterface

/* design/c2xu_rsp_if.sv */
`timescale 1ns / 1ps
interface c2xu_rsp_if;
	logic valid;
	logic ready;
	logic signed [24:0] pixel_out;
	logic out_of_range;

	modport source (output valid, pixel_out, out_of_range, input ready);
	modport sink (input valid, pixel_out, out_of_range, output ready);
endinterface

/* design/c2xu_ctrl.sv */
`timescale 1ns / 1ps
module c2xu_ctrl
	import c2xu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  c2xu_sts_t sts,
	output c2xu_cmd_t cmd
);

	c2xu_state_t state_q;
	c2xu_state_t state_d;
	logic out_valid_q;
	logic in_fire;

	assign in_fire = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && sts.is_read) begin
					state_d = sts.oor ? ST_FINISH : ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (sts.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.write = in_valid && (state_q == ST_IDLE) && !sts.is_read;
		cmd.start = in_valid && (state_q == ST_IDLE) && sts.is_read;
		cmd.issue = (state_q == ST_ISSUE);
		cmd.load = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_drain_then_finish: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |=> state_q == ST_FINISH)
		else $error("drain not followed by finish");
	a_last_issue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) && sts.last_issue |=> state_q == ST_DRAIN)
		else $error("last tap issued but no drain");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("waiting result dropped");
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");
`endif

endmodule

/* design/c2xu_datapath.sv */
`timescale 1ns / 1ps
module c2xu_datapath
	import c2xu_pkg::*;
#(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write_en,
	input  logic                       cfg_index,
	input  logic [DIM_W-1:0]           cfg_data,
	input  logic                       operation,
	input  logic [DIM_W-1:0]           row_index,
	input  logic [DIM_W-1:0]           column_index,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  c2xu_cmd_t                  cmd,
	output c2xu_sts_t                  sts,
	output logic signed [PIX_W-1:0]    pixel_out,
	output logic                       out_of_range
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] eff_w;
	logic [DIM_W-1:0] eff_h;
	logic [DIM_W:0] lim_r;
	logic [DIM_W:0] lim_c;
	logic in_grid;
	logic wr_ok;

	logic [DIM_W-1:0] ri_q [4];
	logic [DIM_W-1:0] ci_q [4];
	logic row_odd_q;
	logic col_odd_q;
	logic oor_q;
	logic [1:0] a_q;
	logic [1:0] b_q;
	logic a_last;
	logic b_last;

	logic signed [SAMPLE_W-1:0] mem [DEPTH];
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] mem_addr;
	logic mem_we;

	logic signed [WT_W-1:0] wr_sel;
	logic signed [WT_W-1:0] wc_sel;
	logic signed [WPROD_W-1:0] w_s1;
	logic valid_s1;
	logic signed [SAMPLE_W-1:0] rdata_s1;
	logic signed [PIX_W-1:0] acc_q;
	logic signed [PIX_W-1:0] pixel_q;
	logic flag_q;

	// one neighbour index on an axis, clamped to the image edge
	function automatic logic [DIM_W-1:0] tap_idx(input logic [DIM_W-2:0] base,
		input logic odd, input logic [1:0] k, input logic [DIM_W-1:0] n);
		logic [DIM_W-1:0] b;
		b = {1'b0, base};
		if (!odd) begin
			return b;
		end
		case (k)
			2'd0: return (b == '0) ? b : b - DIM_W'(1);
			2'd1: return b;
			2'd2: return b + DIM_W'(1);
			default: return ((b + DIM_W'(2)) >= n) ? n - DIM_W'(1) : b + DIM_W'(2);
		endcase
	endfunction

	// register settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, above the maximum acts as the maximum
	always_comb begin
		if (width_q == '0) begin
			eff_w = DIM_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = DIM_W'(MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		if (height_q == '0) begin
			eff_h = DIM_W'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = DIM_W'(MAX_HEIGHT);
		end else begin
			eff_h = height_q;
		end
	end

	assign lim_r = {eff_h, 1'b0} - (DIM_W+1)'(1);
	assign lim_c = {eff_w, 1'b0} - (DIM_W+1)'(1);
	assign in_grid = ({1'b0, row_index} < lim_r) && ({1'b0, column_index} < lim_c);
	assign wr_ok = (row_index < eff_h) && (column_index < eff_w);

	assign a_last = row_odd_q ? (a_q == 2'd3) : 1'b1;
	assign b_last = col_odd_q ? (b_q == 2'd3) : 1'b1;

	always_comb begin
		sts.is_read = (operation == OP_READ);
		sts.oor = !in_grid;
		sts.last_issue = a_last && b_last;
	end

	// tap setup and tap walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			row_odd_q <= 1'b0;
			col_odd_q <= 1'b0;
			oor_q <= 1'b0;
		end else if (cmd.start) begin
			a_q <= '0;
			b_q <= '0;
			row_odd_q <= row_index[0];
			col_odd_q <= column_index[0];
			oor_q <= !in_grid;
		end else if (cmd.issue) begin
			if (b_last) begin
				b_q <= '0;
				a_q <= a_q + 2'd1;
			end else begin
				b_q <= b_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int k = 0; k < 4; k++) begin
				ri_q[k] <= tap_idx(row_index[DIM_W-1:1], row_index[0], 2'(k), eff_h);
				ci_q[k] <= tap_idx(column_index[DIM_W-1:1], column_index[0], 2'(k), eff_w);
			end
		end
	end

	// single-port sample memory
	assign wr_addr = ADDR_W'(row_index) * ADDR_W'(MAX_WIDTH) + ADDR_W'(column_index);
	assign rd_addr = ADDR_W'(ri_q[a_q]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(ci_q[b_q]);
	assign mem_we = cmd.write && wr_ok;
	assign mem_addr = mem_we ? wr_addr : rd_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= sample_in;
		end
		rdata_s1 <= mem[mem_addr];
	end

	assign wr_sel = row_odd_q ? TAP_WEIGHT[a_q] : UNIT_WEIGHT;
	assign wc_sel = col_odd_q ? TAP_WEIGHT[b_q] : UNIT_WEIGHT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		w_s1 <= WPROD_W'(wr_sel * wc_sel);
		if (cmd.start) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			acc_q <= acc_q + PIX_W'(w_s1 * rdata_s1);
		end
		if (cmd.load) begin
			pixel_q <= acc_q;
			flag_q <= oor_q;
		end
	end

	assign pixel_out = pixel_q;
	assign out_of_range = flag_q;

`ifndef SYNTHESIS
	a_s1_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(cmd.issue))
		else $error("read data stage without a read");
	a_start_clears_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (a_q == 2'd0) && (b_q == 2'd0))
		else $error("tap walk not cleared on start");
	a_even_row_one_tap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue && !row_odd_q |-> a_q == 2'd0)
		else $error("extra row tap on even row");
`endif

endmodule

/* design/cubic_2x_image_upscaler_top.sv */
`timescale 1ns / 1ps
// channel   direction  handshake        payload
// req       in         valid / ready    operation, row_index, column_index, sample_in
// rsp       out        valid / ready    pixel_out, out_of_range
// cfg       in         cfg_write_en     cfg_index, cfg_data
//
// a write item gives no result; a read item walks its taps, one for
// even/even, four for one odd axis, sixteen neighbours for odd/odd (one
// read a cycle from the single-port sample memory), then drains the read
// stage and loads the result; an off-grid read goes straight to the load
// arst_n clears control and registers (width and height 8); samples are
// undefined until written
// req is taken only while idle; a finished result waits in the output
// register, and the next item is taken meanwhile
module cubic_2x_image_upscaler_top
	import c2xu_pkg::*;
#(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write_en,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	c2xu_req_if.sink         req,
	c2xu_rsp_if.source       rsp
);

	// command and status between the controller and the datapath
	c2xu_cmd_t cmd;
	c2xu_sts_t sts;

	// sequencer: idle, neighbour walk, drain of the read stage, result load
	c2xu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// settings, tap indices, sample memory, weighted accumulate, output register
	c2xu_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (req.operation),
		.row_index    (req.row_index),
		.column_index (req.column_index),
		.sample_in    (req.sample_in),
		.cmd          (cmd),
		.sts          (sts),
		.pixel_out    (rsp.pixel_out),
		.out_of_range (rsp.out_of_range)
	);

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
	import c2xu_pkg::*;

	// sizes and timing of the run
	localparam int IMG_MAX = 64;
	localparam int RESET_DIM = 8;
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_PER_PHASE = 86;
	localparam int NUM_PHASES = 8;
	localparam int ITEMS_PER_IDLE_MODE = 40;
	localparam longint WATCHDOG_NS = 2_000_000;

	// extreme samples and the copies they give (scaled by 256)
	localparam logic [15:0] S_MAX = 16'h7FFF;
	localparam logic [15:0] S_MIN = 16'h8000;
	localparam logic [24:0] PIX_COPY_MAX = 25'd8388352;
	localparam logic [24:0] PIX_COPY_MIN = 25'h1800000;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	// one row of the directed table; typed rows carry their own expected result
	typedef struct packed {
		row_kind_t kind;
		logic op;
		logic reg_idx;
		logic [6:0] reg_val;
		logic [6:0] row;
		logic [6:0] col;
		logic [15:0] sample;
		logic typed;
		logic [24:0] pix;
		logic oor;
	} dir_row_t;

	typedef struct packed {
		logic [6:0] row;
		logic [6:0] col;
		logic signed [24:0] pix;
		logic oor;
	} pending_pixel_t;

	typedef struct packed {
		logic [6:0] r;
		logic [6:0] c;
	} pix_coord_t;

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	logic cfg_index;
	logic [DIM_W-1:0] cfg_data;
	bit rx_ready;

	c2xu_req_if req_ch ();
	c2xu_rsp_if rsp_ch ();

	assign rsp_ch.ready = rx_ready;

	cubic_2x_image_upscaler_top #(
		.MAX_WIDTH(IMG_MAX),
		.MAX_HEIGHT(IMG_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// our own copy of the source image and the two size registers
	logic signed [15:0] src_img [IMG_MAX*IMG_MAX];
	bit src_written [IMG_MAX*IMG_MAX];
	pix_coord_t written_coords [$];
	logic [6:0] width_reg;
	logic [6:0] height_reg;

	// upscaled pixels still owed by the block, oldest first
	pending_pixel_t pending_pixels [$];
	pending_pixel_t got_exp;

	dir_row_t dir_rows [$];

	// register settings walked after the directed part; 0, 100 and 127 hit the clamps
	logic [6:0] phase_width [NUM_PHASES] = '{7'd5, 7'd2, 7'd1, 7'd127, 7'd0, 7'd100, 7'd3, 7'd64};
	logic [6:0] phase_height [NUM_PHASES] = '{7'd7, 7'd2, 7'd64, 7'd1, 7'd3, 7'd64, 7'd127, 7'd8};

	idle_mode_t idle_mode = IDLE_NONE;
	int items_sent;
	int errors;
	int n_writes, n_ignored, n_settings;
	int n_copy, n_one_odd, n_both_odd, n_off_grid;

	// clock, 4 ns period
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#(WATCHDOG_NS);
		$display("%0t: run did not finish in time, %0d results outstanding", $time,
			pending_pixels.size());
		$display("== FAIL ==");
		$finish;
	end

	// a size register of 0 behaves as 1, anything above the maximum as the maximum
	function automatic int eff_dim(logic [6:0] v, int maxv);
		if (v == 7'd0)
			return 1;
		if (int'(v) > maxv)
			return maxv;
		return int'(v);
	endfunction

	// source index of tap k on one axis, clamped to the image edge
	function automatic int tap_index(int coord, int k, int n);
		int i;
		i = (coord % 2 == 0) ? coord / 2 : coord / 2 - 1 + k;
		if (i < 0)
			return 0;
		if (i >= n)
			return n - 1;
		return i;
	endfunction

	// even coordinates take one tap of 16, odd ones the midpoint taps -1 9 9 -1
	function automatic int tap_weight(int coord, int k);
		if (coord % 2 == 0)
			return 16;
		return (k == 0 || k == 3) ? -1 : 9;
	endfunction

	// expected pixel for an output coordinate; returns 0 when a used sample was never written
	function automatic bit upscale_pixel(input int row, input int col,
			output logic signed [24:0] pix, output logic oor);
		int w, h, a, b, ri, ci;
		longint acc, hsum;
		bit ok;
		w = eff_dim(width_reg, IMG_MAX);
		h = eff_dim(height_reg, IMG_MAX);
		ok = 1'b1;
		acc = 0;
		pix = '0;
		oor = 1'b1;
		if (row >= 2 * h - 1 || col >= 2 * w - 1)
			return ok;
		// horizontal pass per source row, then the vertical weights
		for (a = 0; a < ((row % 2 == 0) ? 1 : 4); a++) begin
			ri = tap_index(row, a, h);
			hsum = 0;
			for (b = 0; b < ((col % 2 == 0) ? 1 : 4); b++) begin
				ci = tap_index(col, b, w);
				ok &= src_written[ri*IMG_MAX+ci];
				hsum += tap_weight(col, b) * src_img[ri*IMG_MAX+ci];
			end
			acc += tap_weight(row, a) * hsum;
		end
		pix = acc[24:0];
		oor = 1'b0;
		return ok;
	endfunction

	// mostly random samples, now and then an extreme
	function automatic logic [15:0] random_sample();
		if ($urandom_range(0, 9) != 0)
			return 16'($urandom);
		case ($urandom_range(0, 3))
			0: return S_MAX;
			1: return S_MIN;
			2: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic void add_item(logic op, logic [6:0] row, logic [6:0] col,
			logic [15:0] sample);
		dir_row_t d;
		d = '0;
		d.kind = ROW_ITEM;
		d.op = op;
		d.row = row;
		d.col = col;
		d.sample = sample;
		dir_rows.push_back(d);
	endfunction

	// a read whose result is plain to see
	function automatic void add_check(logic [6:0] row, logic [6:0] col, logic [24:0] pix,
			logic oor);
		dir_row_t d;
		d = '0;
		d.kind = ROW_ITEM;
		d.op = OP_READ;
		d.row = row;
		d.col = col;
		d.sample = 16'($urandom);
		d.typed = 1'b1;
		d.pix = pix;
		d.oor = oor;
		dir_rows.push_back(d);
	endfunction

	function automatic void add_reg(logic idx, logic [6:0] val);
		dir_row_t d;
		d = '0;
		d.kind = ROW_CFG;
		d.reg_idx = idx;
		d.reg_val = val;
		dir_rows.push_back(d);
	endfunction

	// offer one item, wait for it to be taken, then record its effect
	task automatic send_item(input logic op, input logic [6:0] row, input logic [6:0] col,
			input logic [15:0] sample, input bit typed = 1'b0,
			input logic [24:0] typed_pix = '0, input logic typed_oor = 1'b0);
		int gap_pct, w, h, addr;
		pending_pixel_t p;
		logic signed [24:0] pix;
		logic oor;
		gap_pct = (idle_mode == IDLE_SENDER) ? 78 : (idle_mode == IDLE_BOTH) ? 36 : 0;
		while ($urandom_range(0, 99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.row_index <= row;
		req_ch.column_index <= col;
		req_ch.sample_in <= sample;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		items_sent++;
		idle_mode <= idle_mode_t'((items_sent / ITEMS_PER_IDLE_MODE) % 4);
		if (op == OP_WRITE) begin
			w = eff_dim(width_reg, IMG_MAX);
			h = eff_dim(height_reg, IMG_MAX);
			if (int'(row) < h && int'(col) < w) begin
				addr = int'(row) * IMG_MAX + int'(col);
				src_img[addr] = sample;
				if (!src_written[addr]) begin
					src_written[addr] = 1'b1;
					written_coords.push_back('{r: row, c: col});
				end
				n_writes++;
			end else begin
				n_ignored++;
			end
		end else begin
			void'(upscale_pixel(row, col, pix, oor));
			if (oor)
				n_off_grid++;
			else if (!row[0] && !col[0])
				n_copy++;
			else if (row[0] && col[0])
				n_both_odd++;
			else
				n_one_odd++;
			p.row = row;
			p.col = col;
			p.pix = typed ? typed_pix : pix;
			p.oor = typed ? typed_oor : oor;
			pending_pixels.push_back(p);
		end
	endtask

	// size registers change only with the block idle and every result back
	task automatic write_reg(input logic idx, input logic [6:0] val);
		req_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		// a trailing pixel write may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			width_reg = val;
		else
			height_reg = val;
		n_settings++;
	endtask

	// write every pixel of a rectangle of the source image
	task automatic load_box(input int r0, input int r1, input int c0, input int c1);
		int r, c;
		for (r = r0; r <= r1; r++)
			for (c = c0; c <= c1; c++)
				send_item(OP_WRITE, 7'(r), 7'(c), random_sample());
	endtask

	// receiver: ready stalls at random by idle mode
	always @(posedge clk) begin
		rx_ready <= ($urandom_range(0, 99) >=
			((idle_mode == IDLE_RECEIVER) ? 78 : (idle_mode == IDLE_BOTH) ? 36 : 0));
	end

	// every result taken is compared with the oldest one owed
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rx_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: result with none expected, pixel_out %0d out_of_range %0b",
					$time, rsp_ch.pixel_out, rsp_ch.out_of_range);
				errors++;
			end else begin
				got_exp = pending_pixels.pop_front();
				if (rsp_ch.pixel_out !== got_exp.pix) begin
					$display("%0t: read (%0d,%0d) pixel_out expected %0d actual %0d", $time,
						got_exp.row, got_exp.col, got_exp.pix, rsp_ch.pixel_out);
					errors++;
				end
				if (rsp_ch.out_of_range !== got_exp.oor) begin
					$display("%0t: read (%0d,%0d) out_of_range expected %0b actual %0b",
						$time, got_exp.row, got_exp.col, got_exp.oor, rsp_ch.out_of_range);
					errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int ph, counted, p, r, c, t, w, h;
		logic signed [24:0] pix;
		logic oor;
		bit picked;
		pix_coord_t e;

		arst_n <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.operation <= OP_WRITE;
		req_ch.row_index <= '0;
		req_ch.column_index <= '0;
		req_ch.sample_in <= '0;
		width_reg = 7'(RESET_DIM);
		height_reg = 7'(RESET_DIM);
		for (int i = 0; i < IMG_MAX * IMG_MAX; i++)
			src_written[i] = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, starting from the reset size of 8 by 8
		add_item(OP_WRITE, 7'd0, 7'd0, S_MAX);
		add_check(7'd0, 7'd0, PIX_COPY_MAX, 1'b0);
		// first row off the grid at reset height, and the far corner
		add_check(7'd15, 7'd0, '0, 1'b1);
		add_check(7'd126, 7'd126, '0, 1'b1);
		// write below the image is dropped
		add_item(OP_WRITE, 7'd8, 7'd0, 16'hFFFF);
		// zero sizes act as a 1 by 1 image
		add_reg(REG_IMAGE_WIDTH, 7'd0);
		add_reg(REG_IMAGE_HEIGHT, 7'd0);
		add_check(7'd0, 7'd0, PIX_COPY_MAX, 1'b0);
		add_check(7'd0, 7'd1, '0, 1'b1);
		add_check(7'd1, 7'd0, '0, 1'b1);
		add_item(OP_WRITE, 7'd0, 7'd1, S_MIN);
		// two columns: the midpoint falls back to the plain average
		add_reg(REG_IMAGE_WIDTH, 7'd2);
		add_item(OP_WRITE, 7'd0, 7'd1, S_MIN);
		add_item(OP_READ, 7'd0, 7'd1, 16'hA5A5);
		add_check(7'd0, 7'd2, PIX_COPY_MIN, 1'b0);
		// oversized width clamps to the maximum
		add_reg(REG_IMAGE_WIDTH, 7'd127);
		add_reg(REG_IMAGE_HEIGHT, 7'd2);
		// overshoot pattern for the largest horizontal midpoint
		add_item(OP_WRITE, 7'd0, 7'd0, S_MIN);
		add_item(OP_WRITE, 7'd0, 7'd1, S_MAX);
		add_item(OP_WRITE, 7'd0, 7'd2, S_MAX);
		add_item(OP_WRITE, 7'd0, 7'd3, S_MIN);
		add_item(OP_READ, 7'd0, 7'd3, 16'h5A5A);
		add_item(OP_WRITE, 7'd0, 7'd63, S_MAX);
		add_check(7'd0, 7'd126, PIX_COPY_MAX, 1'b0);
		add_check(7'd3, 7'd0, '0, 1'b1);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			else
				send_item(dir_rows[i].op, dir_rows[i].row, dir_rows[i].col,
					dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].pix, dir_rows[i].oor);
		end

		// random part, one width and one height setting per phase
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			write_reg(REG_IMAGE_WIDTH, phase_width[ph]);
			write_reg(REG_IMAGE_HEIGHT, phase_height[ph]);
			w = eff_dim(width_reg, IMG_MAX);
			h = eff_dim(height_reg, IMG_MAX);
			// small images are loaded whole, large ones near two opposite corners
			if (w * h <= 256) begin
				load_box(0, h - 1, 0, w - 1);
			end else begin
				load_box(0, ((h < 6) ? h : 6) - 1, 0, ((w < 10) ? w : 10) - 1);
				load_box((h > 6) ? h - 6 : 0, h - 1, (w > 10) ? w - 10 : 0, w - 1);
			end
			counted = 0;
			while (counted < RANDOM_PER_PHASE) begin
				p = $urandom_range(0, 99);
				if (p < 40) begin
					send_item(OP_WRITE, 7'($urandom_range(0, h - 1)),
						7'($urandom_range(0, w - 1)), random_sample());
					counted++;
				end else if (p < 45) begin
					// write off the image, dropped by the block
					r = $urandom_range(0, 126);
					c = $urandom_range(0, 126);
					if ($urandom_range(0, 1))
						r = $urandom_range(h, 126);
					else
						c = $urandom_range(w, 126);
					send_item(OP_WRITE, 7'(r), 7'(c), random_sample());
				end else begin
					picked = 1'b0;
					// some reads anywhere in the field range
					if (p < 55) begin
						r = $urandom_range(0, 126);
						c = $urandom_range(0, 126);
						picked = upscale_pixel(r, c, pix, oor);
					end
					// the rest near a written sample, so every tap is defined
					for (t = 0; t < 8 && !picked; t++) begin
						e = written_coords[$urandom_range(0, written_coords.size() - 1)];
						r = 2 * int'(e.r) + int'($urandom_range(0, 2)) - 1;
						c = 2 * int'(e.c) + int'($urandom_range(0, 2)) - 1;
						r = (r < 0) ? 0 : (r > 126) ? 126 : r;
						c = (c < 0) ? 0 : (c > 126) ? 126 : c;
						picked = upscale_pixel(r, c, pix, oor);
					end
					if (!picked) begin
						r = 0;
						c = 0;
					end
					send_item(OP_READ, 7'(r), 7'(c), 16'($urandom));
					counted++;
				end
			end
		end

		// drain, then let the block settle
		req_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d pixel writes (%0d dropped) and %0d reads over %0d register writes",
			n_writes, n_ignored, n_copy + n_one_odd + n_both_odd + n_off_grid, n_settings);
		$display("reads: %0d copies, %0d one odd axis, %0d both odd, %0d off grid, %0d errors",
			n_copy, n_one_odd, n_both_odd, n_off_grid, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* cubic_2x_image_upscaler_top.f */
design/c2xu_pkg.sv
design/c2xu_req_if.sv
design/c2xu_rsp_if.sv
design/c2xu_ctrl.sv
design/c2xu_datapath.sv
design/cubic_2x_image_upscaler_top.sv
sim/tb.sv
